>>> src/complex_arithmetic_unit_defines.svh
// Assertion macros for the complex arithmetic unit.
// Each macro expects clk and rst_n to be in scope.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex_arithmetic_unit: check failed");

// Next-cycle implication.
`define CAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex_arithmetic_unit: check failed");

`endif

>>> src/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and widths for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int W    = 16;           // word bits
    localparam int F    = 8;            // fraction bits
    localparam int PW   = 2 * W;        // product width
    localparam int SW   = 2 * W + 1;    // sum of two products
    localparam int MW   = 2 * W;        // magnitude width
    localparam int DENW = 2 * W;        // divisor width
    localparam int QB   = W + 1;        // quotient bits kept
    localparam int CW   = 2 * W + QB;   // divider compare width
    localparam int FE_STAGES   = 3;
    localparam int DIV_STAGES  = QB + 1;
    localparam int PIPE_STAGES = FE_STAGES + DIV_STAGES;

    localparam logic signed [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_MUL  = 2'd1,
        OP_DIV  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic signed [W-1:0] a_re;
        logic signed [W-1:0] a_im;
        logic signed [W-1:0] b_re;
        logic signed [W-1:0] b_im;
    } cau_in_t;

    typedef struct packed {
        logic signed [W-1:0] res_re;
        logic signed [W-1:0] res_im;
        logic                saturated;
        logic                div_by_zero;
    } cau_out_t;

    // sign/magnitude parts and divide control after the front end
    typedef struct packed {
        op_t             op;
        logic            re_neg;
        logic [MW-1:0]   re_mag;
        logic            im_neg;
        logic [MW-1:0]   im_mag;
        logic [DENW-1:0] den;
        logic            dz;
    } cau_ctl_t;

endpackage

>>> src/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Three stages: products, combined sums, sign/magnitude split.
// ----------------------------------------------------------------------------
module cau_front
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  cau_in_t  din,
    output cau_ctl_t dout
);

    logic signed [W-1:0] ar, ai, br, bi;
    assign ar = din.a_re;
    assign ai = din.a_im;
    assign br = din.b_re;
    assign bi = din.b_im;

    // stage 1
    op_t                  op1_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg, sqr_reg, sqi_reg;
    logic signed [W:0]    sre_reg, sim_reg;
    logic signed [PW-1:0] prr_next, pii_next, pri_next, pir_next, sqr_next, sqi_next;
    logic signed [W:0]    sre_next, sim_next;

    assign prr_next = PW'(ar) * PW'(br);
    assign pii_next = PW'(ai) * PW'(bi);
    assign pri_next = PW'(ar) * PW'(bi);
    assign pir_next = PW'(br) * PW'(ai);
    assign sqr_next = PW'(br) * PW'(br);
    assign sqi_next = PW'(bi) * PW'(bi);
    assign sre_next = (W+1)'(ar) + (W+1)'(br);
    assign sim_next = (W+1)'(ai) + (W+1)'(bi);

    // stage 2
    op_t                  op2_reg;
    logic signed [SW-1:0] s_re_reg, s_im_reg, s_re_next, s_im_next;
    logic [DENW-1:0]      den2_reg, den2_next;

    always_comb
    begin
        case (op1_reg)
            OP_ADD:
            begin
                s_re_next = SW'(sre_reg);
                s_im_next = SW'(sim_reg);
            end
            OP_MUL:
            begin
                s_re_next = SW'(prr_reg) - SW'(pii_reg);
                s_im_next = SW'(pri_reg) + SW'(pir_reg);
            end
            OP_DIV:
            begin
                s_re_next = SW'(prr_reg) + SW'(pii_reg);
                s_im_next = SW'(pir_reg) - SW'(pri_reg);
            end
            default:
            begin
                s_re_next = '0;
                s_im_next = '0;
            end
        endcase
        den2_next = DENW'($unsigned(sqr_reg)) + DENW'($unsigned(sqi_reg));
    end

    // stage 3
    cau_ctl_t             ctl_reg, ctl_next;
    logic signed [SW-1:0] abs_re, abs_im;

    always_comb
    begin
        abs_re = s_re_reg[SW-1] ? -s_re_reg : s_re_reg;
        abs_im = s_im_reg[SW-1] ? -s_im_reg : s_im_reg;
        ctl_next.op     = op2_reg;
        ctl_next.re_neg = s_re_reg[SW-1];
        ctl_next.im_neg = s_im_reg[SW-1];
        ctl_next.re_mag = abs_re[MW-1:0];
        ctl_next.im_mag = abs_im[MW-1:0];
        if (op2_reg == OP_MUL)
        begin
            // sign/magnitude shift truncates toward zero
            ctl_next.re_mag = abs_re[MW-1:0] >> F;
            ctl_next.im_mag = abs_im[MW-1:0] >> F;
        end
        ctl_next.den = den2_reg;
        ctl_next.dz  = (op2_reg == OP_DIV) && (den2_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg  <= op_t'(din.opcode);
            prr_reg  <= prr_next;
            pii_reg  <= pii_next;
            pri_reg  <= pri_next;
            pir_reg  <= pir_next;
            sqr_reg  <= sqr_next;
            sqi_reg  <= sqi_next;
            sre_reg  <= sre_next;
            sim_reg  <= sim_next;
            op2_reg  <= op1_reg;
            s_re_reg <= s_re_next;
            s_im_reg <= s_im_next;
            den2_reg <= den2_next;
            ctl_reg  <= ctl_next;
        end
    end

    assign dout = ctl_reg;

endmodule

>>> src/cau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider: trunc(num * 2^F / den), one quotient bit per
// stage, clamped to 2^W when the quotient does not fit.
// ----------------------------------------------------------------------------
module cau_div
    import cau_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  logic [MW-1:0]   num_mag,
    input  logic [DENW-1:0] den,
    output logic [MW-1:0]   quo_mag
);

    logic [CW-1:0]   rem_reg  [0:QB];
    logic [DENW-1:0] den_reg  [0:QB];
    logic [QB-1:0]   quo_reg  [0:QB];
    logic            ovf_reg  [0:QB];
    logic [CW-1:0]   rem_next [0:QB];
    logic [QB-1:0]   quo_next [0:QB];
    logic [CW-1:0]   dvd;

    always_comb
    begin
        logic [CW-1:0] dsh;
        dvd         = CW'(num_mag) << F;
        rem_next[0] = dvd;
        quo_next[0] = '0;
        for (int i = 0; i < QB; i++)
        begin
            dsh = CW'(den_reg[i]) << (QB - 1 - i);
            if (rem_reg[i] >= dsh)
            begin
                rem_next[i+1] = rem_reg[i] - dsh;
                quo_next[i+1] = {quo_reg[i][QB-2:0], 1'b1};
            end
            else
            begin
                rem_next[i+1] = rem_reg[i];
                quo_next[i+1] = {quo_reg[i][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next[0];
            quo_reg[0] <= quo_next[0];
            den_reg[0] <= den;
            ovf_reg[0] <= dvd >= (CW'(den) << QB);
            for (int i = 1; i <= QB; i++)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= den_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    assign quo_mag = ovf_reg[QB] ? (MW'(1) << W) : MW'(quo_reg[QB]);

endmodule

>>> src/cau_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pack
// Result select and saturation to the word range.
// ----------------------------------------------------------------------------
module cau_pack
    import cau_pkg::*;
(
    input  cau_ctl_t      ctl,
    input  logic [MW-1:0] quo_re,
    input  logic [MW-1:0] quo_im,
    output cau_out_t      res
);

    logic [MW-1:0] mre, mim;
    logic          sat_re, sat_im;
    logic [MW-1:0] lim_pos, lim_neg;

    assign lim_pos = MW'($unsigned(WORD_MAX));
    assign lim_neg = MW'(1) << (W - 1);

    always_comb
    begin
        logic [MW-1:0] cre, cim;
        mre = ctl.re_mag;
        mim = ctl.im_mag;
        if (ctl.op == OP_DIV)
        begin
            mre = ctl.dz ? '0 : quo_re;
            mim = ctl.dz ? '0 : quo_im;
        end
        else if (ctl.op == OP_NONE)
        begin
            mre = '0;
            mim = '0;
        end

        sat_re = ctl.re_neg ? (mre > lim_neg) : (mre > lim_pos);
        sat_im = ctl.im_neg ? (mim > lim_neg) : (mim > lim_pos);
        cre = sat_re ? (ctl.re_neg ? lim_neg : lim_pos) : mre;
        cim = sat_im ? (ctl.im_neg ? lim_neg : lim_pos) : mim;

        res.res_re      = ctl.re_neg ? -cre[W-1:0] : cre[W-1:0];
        res.res_im      = ctl.im_neg ? -cim[W-1:0] : cim[W-1:0];
        res.saturated   = sat_re || sat_im;
        res.div_by_zero = ctl.dz;
    end

endmodule

>>> src/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Pipeline from op transfer to res_valid: 3 front-end, 18 divider and 1 output register stages.
// Throughput: one operation per cycle while no result stalls; the 17-stage bit-per-stage divider is
// pipelined, so divide, add and multiply all stream at full rate.
// A stalled result holds the whole pipeline in place.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, multiply and divide on signed Q8.8 operands with saturation.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     op_valid,
    output logic     op_ready,
    input  cau_in_t  op_data,
    output logic     res_valid,
    input  logic     res_ready,
    output cau_out_t res_data
);

    logic     adv;
    logic     vld_reg [0:PIPE_STAGES-1];
    logic     res_valid_reg;
    cau_out_t res_data_reg, res_next;
    cau_ctl_t fe_out;
    cau_ctl_t ctl_reg [0:QB];
    logic [MW-1:0] quo_re, quo_im;

    // whole pipe moves when the output slot is free or being drained
    assign adv      = !res_valid_reg || res_ready;
    assign op_ready = adv;

    cau_front u_front (
        .clk  (clk),
        .en   (adv),
        .din  (op_data),
        .dout (fe_out)
    );

    cau_div u_div_re (
        .clk     (clk),
        .en      (adv),
        .num_mag (fe_out.re_mag),
        .den     (fe_out.den),
        .quo_mag (quo_re)
    );

    cau_div u_div_im (
        .clk     (clk),
        .en      (adv),
        .num_mag (fe_out.im_mag),
        .den     (fe_out.den),
        .quo_mag (quo_im)
    );

    cau_pack u_pack (
        .ctl    (ctl_reg[QB]),
        .quo_re (quo_re),
        .quo_im (quo_im),
        .res    (res_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= fe_out;
            for (int i = 1; i <= QB; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            res_data_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= op_valid;
            for (int i = 1; i < PIPE_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            res_valid_reg <= vld_reg[PIPE_STAGES-1];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    `CAU_ASSERT_NXT(a_last_stage_lands, vld_reg[PIPE_STAGES-1] && adv, res_valid)
    `CAU_ASSERT_IMP(a_dz_gives_zero, res_valid && res_data.div_by_zero,
                    res_data.res_re == '0 && res_data.res_im == '0 && !res_data.saturated)
    `CAU_ASSERT_IMP(a_sat_at_limit, res_valid && res_data.saturated,
                    res_data.res_re == WORD_MAX || res_data.res_re == WORD_MIN ||
                    res_data.res_im == WORD_MAX || res_data.res_im == WORD_MIN)

endmodule
